// ----- rtl/ppd_pkg.sv -----
// ---------------------------------------------------------------------------
// ppd_pkg: shared definitions for the ping-pong receive drain control
// Widths, codes, payload structs and the window-to-quarter helper.
// ---------------------------------------------------------------------------
package ppd_pkg;

    // Sizes and limits
    localparam int unsigned CHUNK_LIMIT  = 4096;
    localparam int unsigned MAX_WINDOW   = 65536;
    localparam int unsigned MIN_WINDOW   = 256;
    localparam int unsigned WINDOW_RESET = 4096;

    // Field widths
    localparam int unsigned WIN_W  = 17;
    localparam int unsigned PTR_W  = 16;
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned Q_W    = 15;   // quarter window, up to 16384
    localparam int unsigned CYC_W  = 16;   // drain cycle, up to 32768

    // Offset re-wrap after a window change: one quotient bit per cycle
    localparam int unsigned RED_STEPS = 9;
    localparam int unsigned RED_CNT_W = 4;
    localparam int unsigned RED_SH_W  = CYC_W + RED_STEPS - 1;

    // Register port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [0:0]  REG_WINDOW = 1'b0;

    // Receive modes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LISTEN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OVERFLOW = 2'd2;

    // Rewrite kinds
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INIT     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVF_RST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFILL   = 2'd3;

    typedef struct packed {
        logic [PTR_W-1:0]  prime_ptr;
        logic [PTR_W-1:0]  prime_len;
        logic [PTR_W-1:0]  alt_ptr;
        logic [PTR_W-1:0]  alt_len;
        logic [MODE_W-1:0] rx_mode;
    } ppd_snap_t;

    typedef struct packed {
        logic [PTR_W-1:0]  read_addr;
        logic [LEN_W-1:0]  first_len;
        logic [PTR_W-1:0]  flip_addr;
        logic [LEN_W-1:0]  flip_len;
        logic [KIND_W-1:0] rewrite_kind;
        logic [PTR_W-1:0]  new_prime_ptr;
        logic [PTR_W-1:0]  new_prime_len;
        logic [PTR_W-1:0]  new_alt_ptr;
        logic [PTR_W-1:0]  new_alt_len;
        logic [MODE_W-1:0] new_mode;
        logic              fault;
    } ppd_result_t;

    typedef struct packed {
        logic             we;
        logic [CYC_W-1:0] value;
    } ppd_off_upd_t;

    // Saturate to 256..65536, round down to 256, then take a quarter.
    function automatic logic [Q_W-1:0] quarter_of(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] e;
        if (w < WIN_W'(MIN_WINDOW)) begin
            e = WIN_W'(MIN_WINDOW);
        end else if (w > WIN_W'(MAX_WINDOW)) begin
            e = WIN_W'(MAX_WINDOW);
        end else begin
            e = w;
        end
        e[7:0] = 8'h00;
        return e[WIN_W-1:2];
    endfunction

endpackage

// ----- rtl/ppd_regs.sv -----
// ---------------------------------------------------------------------------
// ppd_regs: register port
// Holds window_size and the derived quarter size; flags window writes.
// ---------------------------------------------------------------------------
module ppd_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppd_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppd_pkg::DATA_W-1:0]  pwdata,
    output logic [ppd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [ppd_pkg::Q_W-1:0]     quarter,
    output logic                        window_wr
);
    import ppd_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic [Q_W-1:0]   quarter_reg;
    logic             hit;

    assign pready    = 1'b1;
    assign hit       = (paddr[ADDR_W-1:2] == REG_WINDOW);
    assign window_wr = psel && penable && pwrite && pready && hit;
    assign quarter   = quarter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WIN_W'(WINDOW_RESET);
            quarter_reg <= quarter_of(WIN_W'(WINDOW_RESET));
        end else if (window_wr) begin
            window_reg  <= pwdata[WIN_W-1:0];
            quarter_reg <= quarter_of(pwdata[WIN_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = DATA_W'(window_reg);
        end
    end

endmodule

// ----- rtl/ppd_offset.sv -----
// ---------------------------------------------------------------------------
// ppd_offset: drain offset register
// Keeps the offset; re-wraps it into a new drain cycle by shift-subtract.
// ---------------------------------------------------------------------------
module ppd_offset (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ppd_pkg::Q_W-1:0]     quarter,
    input  ppd_pkg::ppd_off_upd_t       upd,
    output logic [ppd_pkg::CYC_W-1:0]   offset,
    output logic                        busy
);
    import ppd_pkg::*;

    logic [CYC_W-1:0]     off_reg,  off_next;
    logic                 busy_reg, busy_next;
    logic [RED_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [RED_SH_W-1:0]  div_sh;

    assign div_sh = RED_SH_W'({quarter, 1'b0}) << cnt_reg;
    assign offset = off_reg;
    assign busy   = busy_reg;

    always_comb begin
        off_next  = off_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = RED_CNT_W'(RED_STEPS - 1);
        end else if (busy_reg) begin
            if (RED_SH_W'(off_reg) >= div_sh) begin
                off_next = off_reg - div_sh[CYC_W-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end else if (upd.we) begin
            off_next = upd.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            off_reg  <= off_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- rtl/ppd_step.sv -----
// ---------------------------------------------------------------------------
// ppd_step: per-snapshot decision logic
// Reads, rewrite choice, consistency checks and next drain offset.
// ---------------------------------------------------------------------------
module ppd_step (
    input  ppd_pkg::ppd_snap_t          snap,
    input  logic [ppd_pkg::Q_W-1:0]     quarter,
    input  logic [ppd_pkg::CYC_W-1:0]   offset,
    output ppd_pkg::ppd_result_t        res,
    output ppd_pkg::ppd_off_upd_t       upd
);
    import ppd_pkg::*;

    logic [CYC_W-1:0] cyc;
    logic [PTR_W:0]   ep, ea;
    logic             ep_q, ep_c, ea_q, ea_c, ea_zero;
    logic             rh, rrh, unread, fault;
    logic [Q_W-1:0]   rho, base_rh, base_ot, nb;
    logic [PTR_W-1:0] d_rh, d_ot;
    logic [Q_W-1:0]   rl_raw, rlf_raw;
    logic [CYC_W-1:0] raw_sum;
    logic [LEN_W-1:0] rl_c, rlf_c;
    logic [CYC_W:0]   nsum;
    logic [CYC_W-1:0] noff;
    ppd_result_t      body;

    always_comb begin
        cyc     = {quarter, 1'b0};
        ep      = {1'b0, snap.prime_ptr} + {1'b0, snap.prime_len};
        ea      = {1'b0, snap.alt_ptr} + {1'b0, snap.alt_len};
        ep_q    = (ep == (PTR_W+1)'(quarter));
        ep_c    = (ep == (PTR_W+1)'(cyc));
        ea_q    = (ea == (PTR_W+1)'(quarter));
        ea_c    = (ea == (PTR_W+1)'(cyc));
        ea_zero = (ea == '0);

        // which half the offset sits in
        rh      = (offset >= CYC_W'(quarter));
        rho     = rh ? Q_W'(offset - CYC_W'(quarter)) : offset[Q_W-1:0];
        base_rh = rh ? quarter : '0;
        base_ot = rh ? '0 : quarter;
        d_rh    = snap.prime_ptr - PTR_W'(base_rh);
        d_ot    = snap.prime_ptr - PTR_W'(base_ot);

        fault   = 1'b0;
        rl_raw  = '0;
        rlf_raw = '0;
        if (!ep_q && !ep_c) fault = 1'b1;
        if (ep == ea) fault = 1'b1;
        if (!ea_zero && !ea_q && !ea_c) fault = 1'b1;

        if (ea_zero) begin
            // alternate unset: finish this half, then the other up to the pointer
            if (rh != ep_q) fault = 1'b1;
            rl_raw = quarter - rho;
            if (snap.prime_ptr < PTR_W'(base_ot) || d_ot > PTR_W'(quarter)) begin
                fault = 1'b1;
            end else begin
                rlf_raw = d_ot[Q_W-1:0];
            end
        end else begin
            if (rh == ep_q) fault = 1'b1;
            if (snap.prime_ptr < PTR_W'(base_rh) || d_rh < PTR_W'(rho)
                    || d_rh > PTR_W'(quarter)) begin
                fault = 1'b1;
            end else begin
                rl_raw = Q_W'(d_rh - PTR_W'(rho));
            end
        end

        // cap both reads together at the chunk limit
        raw_sum = CYC_W'(rl_raw) + CYC_W'(rlf_raw);
        if (rl_raw > Q_W'(CHUNK_LIMIT)) begin
            rl_c  = LEN_W'(CHUNK_LIMIT);
            rlf_c = '0;
        end else if (raw_sum > CYC_W'(CHUNK_LIMIT)) begin
            rl_c  = rl_raw[LEN_W-1:0];
            rlf_c = LEN_W'(Q_W'(CHUNK_LIMIT) - rl_raw);
        end else begin
            rl_c  = rl_raw[LEN_W-1:0];
            rlf_c = rlf_raw[LEN_W-1:0];
        end

        if (snap.rx_mode == MODE_OVERFLOW && snap.prime_len != '0) fault = 1'b1;

        nsum = (CYC_W+1)'(offset) + (CYC_W+1)'(rl_c) + (CYC_W+1)'(rlf_c);
        if (nsum >= (CYC_W+1)'(cyc)) begin
            nsum = nsum - (CYC_W+1)'(cyc);
        end
        noff   = nsum[CYC_W-1:0];
        rrh    = (noff >= CYC_W'(quarter));
        unread = (!rrh && ep_c) || (rrh && ep_q);
        nb     = ep_c ? '0 : quarter;

        body               = '0;
        body.read_addr     = offset;
        body.first_len     = rl_c;
        body.flip_addr     = PTR_W'(base_ot);
        body.flip_len      = rlf_c;
        body.rewrite_kind  = KIND_NONE;
        body.new_prime_ptr = snap.prime_ptr;
        body.new_prime_len = snap.prime_len;
        body.new_alt_ptr   = snap.alt_ptr;
        body.new_alt_len   = snap.alt_len;
        body.new_mode      = snap.rx_mode;

        if (unread) begin
            if (!ea_zero) fault = 1'b1;
        end else if (snap.rx_mode == MODE_OVERFLOW) begin
            body.rewrite_kind  = KIND_OVF_RST;
            body.new_prime_ptr = PTR_W'(nb);
            body.new_prime_len = PTR_W'(quarter);
            body.new_alt_ptr   = '0;
            body.new_alt_len   = '0;
            body.new_mode      = MODE_LISTEN;
        end else if (ea_zero) begin
            if (snap.rx_mode != MODE_LISTEN) fault = 1'b1;
            body.rewrite_kind = KIND_REFILL;
            body.new_alt_ptr  = PTR_W'(nb);
            body.new_alt_len  = PTR_W'(quarter);
        end

        res       = '0;
        upd.we    = 1'b0;
        upd.value = '0;
        if (snap.rx_mode == MODE_IDLE) begin
            res.rewrite_kind  = KIND_INIT;
            res.new_prime_len = PTR_W'(quarter);
            res.new_alt_ptr   = PTR_W'(quarter);
            res.new_alt_len   = PTR_W'(quarter);
            res.new_mode      = MODE_LISTEN;
            upd.we            = 1'b1;
        end else if (fault) begin
            res.fault = 1'b1;
        end else begin
            res       = body;
            upd.we    = 1'b1;
            upd.value = noff;
        end
    end

endmodule

// ----- rtl/ping_pong_rx_drain_control_top.sv -----
// ---------------------------------------------------------------------------
// ping_pong_rx_drain_control_top: ping-pong receive drain control
// Turns receiver register snapshots into drain reads and register rewrites.
// ---------------------------------------------------------------------------
// A word accepted into the input stage is registered in the result stage
// before it is offered on m_. Throughput: one word per cycle unless m_ready
// or a re-wrap holds it off; the drain offset moves as each word moves on.
// A window_size write holds s_ready low while the offset is re-wrapped into
// the new drain cycle (9 shift-subtract steps). Reset (aresetn low,
// synchronous): both stages empty, offset 0, window_size 4096.
module ping_pong_rx_drain_control_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB-style register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppd_pkg::ADDR_W-1:0]  paddr,
    input  logic [ppd_pkg::DATA_W-1:0]  pwdata,
    output logic [ppd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // snapshot input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ppd_pkg::PTR_W-1:0]   s_prime_ptr,
    input  logic [ppd_pkg::PTR_W-1:0]   s_prime_len,
    input  logic [ppd_pkg::PTR_W-1:0]   s_alt_ptr,
    input  logic [ppd_pkg::PTR_W-1:0]   s_alt_len,
    input  logic [ppd_pkg::MODE_W-1:0]  s_rx_mode,
    // result output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ppd_pkg::PTR_W-1:0]   m_read_addr,
    output logic [ppd_pkg::LEN_W-1:0]   m_first_len,
    output logic [ppd_pkg::PTR_W-1:0]   m_flip_addr,
    output logic [ppd_pkg::LEN_W-1:0]   m_flip_len,
    output logic [ppd_pkg::KIND_W-1:0]  m_rewrite_kind,
    output logic [ppd_pkg::PTR_W-1:0]   m_new_prime_ptr,
    output logic [ppd_pkg::PTR_W-1:0]   m_new_prime_len,
    output logic [ppd_pkg::PTR_W-1:0]   m_new_alt_ptr,
    output logic [ppd_pkg::PTR_W-1:0]   m_new_alt_len,
    output logic [ppd_pkg::MODE_W-1:0]  m_new_mode,
    output logic                        m_fault
);
    import ppd_pkg::*;

    logic [Q_W-1:0]   quarter;
    logic             window_wr;
    logic [CYC_W-1:0] offset;
    logic             busy;

    // input stage
    ppd_snap_t   snap_reg;
    logic        in_vld_reg;
    // result stage
    ppd_result_t res_reg;
    logic        out_vld_reg;

    ppd_result_t  step_res;
    ppd_off_upd_t step_upd;
    ppd_off_upd_t off_upd;
    logic         advance;
    logic         s_take;

    ppd_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .quarter   (quarter),
        .window_wr (window_wr)
    );

    // Result stage frees up when empty or being taken this cycle.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    // Input stage takes a word when empty or moving on; held off while the
    // offset is being re-wrapped after a window change.
    assign s_ready = !busy && !window_wr && (!in_vld_reg || advance);
    assign s_take  = s_valid && s_ready;

    ppd_step u_step (
        .snap    (snap_reg),
        .quarter (quarter),
        .offset  (offset),
        .res     (step_res),
        .upd     (step_upd)
    );

    // offset only moves when the word actually goes through to the result stage
    always_comb begin
        off_upd    = step_upd;
        off_upd.we = step_upd.we && advance;
    end

    ppd_offset u_offset (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (window_wr),
        .quarter (quarter),
        .upd     (off_upd),
        .offset  (offset),
        .busy    (busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            snap_reg.prime_ptr <= s_prime_ptr;
            snap_reg.prime_len <= s_prime_len;
            snap_reg.alt_ptr   <= s_alt_ptr;
            snap_reg.alt_len   <= s_alt_len;
            snap_reg.rx_mode   <= s_rx_mode;
        end
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_read_addr     = res_reg.read_addr;
    assign m_first_len     = res_reg.first_len;
    assign m_flip_addr     = res_reg.flip_addr;
    assign m_flip_len      = res_reg.flip_len;
    assign m_rewrite_kind  = res_reg.rewrite_kind;
    assign m_new_prime_ptr = res_reg.new_prime_ptr;
    assign m_new_prime_len = res_reg.new_prime_len;
    assign m_new_alt_ptr   = res_reg.new_alt_ptr;
    assign m_new_alt_len   = res_reg.new_alt_len;
    assign m_new_mode      = res_reg.new_mode;
    assign m_fault         = res_reg.fault;

endmodule

// ----- rtl/ppd_checker.sv -----
// ---------------------------------------------------------------------------
// ppd_checker: port-level checks
// Watches the top level's ports; attached by bind.
// ---------------------------------------------------------------------------
module ppd_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [ppd_pkg::PTR_W-1:0]   m_read_addr,
    input  logic [ppd_pkg::LEN_W-1:0]   m_first_len,
    input  logic [ppd_pkg::LEN_W-1:0]   m_flip_len,
    input  logic [ppd_pkg::KIND_W-1:0]  m_rewrite_kind,
    input  logic [ppd_pkg::PTR_W-1:0]   m_new_prime_len,
    input  logic [ppd_pkg::PTR_W-1:0]   m_new_alt_ptr,
    input  logic [ppd_pkg::PTR_W-1:0]   m_new_alt_len,
    input  logic [ppd_pkg::MODE_W-1:0]  m_new_mode,
    input  logic                        m_fault
);
    import ppd_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_addr)
            && $stable(m_first_len) && $stable(m_rewrite_kind) && $stable(m_fault))
        else $error("result word changed while stalled");

    // a rejected snapshot carries nothing else
    a_fault_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault |-> m_first_len == '0 && m_flip_len == '0
            && m_rewrite_kind == KIND_NONE && m_new_prime_len == '0
            && m_new_alt_len == '0 && m_new_mode == MODE_IDLE)
        else $error("fault word has non-zero fields");

    // initialise words carry no reads and restart listening
    a_init: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rewrite_kind == KIND_INIT |-> !m_fault && m_first_len == '0
            && m_flip_len == '0 && m_new_mode == MODE_LISTEN
            && m_new_alt_ptr == m_new_prime_len)
        else $error("malformed initialise word");

    // both reads together stay within the chunk limit
    a_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (LEN_W+1)'(m_first_len) + (LEN_W+1)'(m_flip_len)
            <= (LEN_W+1)'(CHUNK_LIMIT))
        else $error("reads exceed chunk limit");

    // output stage empty straight after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ping_pong_rx_drain_control_top ppd_checker u_ppd_checker (.*);

// ----- tb/sv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: ping-pong receive drain control
// Drives receiver register snapshots through the block and checks each
// result word against a predictor that tracks the drain offset and the
// window setting. The run starts with a directed part under the reset
// window, then random phases under a series of window settings. Both
// channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

    import ppd_pkg::*;

    // Receive mode with no name in the package; handled as a plain non-idle mode
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam int unsigned CLK_HALF       = 6;
    localparam int unsigned TIMEOUT_CYCLES = 200000;
    localparam int unsigned PHASE_WORDS    = 107;
    localparam int unsigned REPORT_LIMIT   = 50;

    // -----------------------------------------------------------------------
    // Scoreboard: predicts the drain plan for each accepted snapshot and
    // compares result words, oldest first.
    // -----------------------------------------------------------------------
    class drain_checker;
        int unsigned window_reg;
        int unsigned drain_offset;
        int unsigned mismatches;
        int unsigned plans_checked;
        ppd_result_t pending_plans[$];

        function new();
            window_reg    = WINDOW_RESET;
            drain_offset  = 0;
            mismatches    = 0;
            plans_checked = 0;
        endfunction

        function void set_window(int unsigned value);
            window_reg = value & 32'h1FFFF;
        endfunction

        // Saturate, round down to 256, take a quarter
        function int unsigned quarter();
            int unsigned w;
            w = window_reg & 32'h1FFFF;
            if (w < MIN_WINDOW) w = MIN_WINDOW;
            if (w > MAX_WINDOW) w = MAX_WINDOW;
            w = w & ~32'hFF;
            return w / 4;
        endfunction

        function ppd_result_t drain_plan(ppd_snap_t s);
            int unsigned q, cyc, p, pl, a, al, ep, ea, off, rho;
            int unsigned base_rh, base_ot, rl, rlf, noff, nb;
            bit rh, unread, bad;
            ppd_result_t r;
            q   = quarter();
            cyc = 2 * q;
            p   = 32'(s.prime_ptr);
            pl  = 32'(s.prime_len);
            a   = 32'(s.alt_ptr);
            al  = 32'(s.alt_len);
            r   = '0;
            bad = 1'b0;

            if (s.rx_mode == MODE_IDLE) begin
                drain_offset    = 0;
                r.rewrite_kind  = KIND_INIT;
                r.new_prime_len = PTR_W'(q);
                r.new_alt_ptr   = PTR_W'(q);
                r.new_alt_len   = PTR_W'(q);
                r.new_mode      = MODE_LISTEN;
                return r;
            end

            ep = p + pl;
            ea = a + al;
            if (ep != q && ep != cyc) bad = 1'b1;
            if (ep == ea) bad = 1'b1;
            if (ea != 0 && ea != q && ea != cyc) bad = 1'b1;

            // offset may be stale after a window change
            off     = drain_offset % cyc;
            rh      = (off >= q);
            rho     = rh ? off - q : off;
            base_rh = rh ? q : 0;
            base_ot = rh ? 0 : q;
            rl      = 0;
            rlf     = 0;

            if (ea == 0) begin
                // alternate unset: finish the read half, then follow prime
                if (rh != (ep == q)) bad = 1'b1;
                rl = q - rho;
                if (p < base_ot || p - base_ot > q) bad = 1'b1;
                else rlf = p - base_ot;
            end else begin
                if (rh != (ep != q)) bad = 1'b1;
                if (p < base_rh || p - base_rh < rho || p - base_rh > q) bad = 1'b1;
                else rl = p - base_rh - rho;
            end

            if (rl > CHUNK_LIMIT) begin
                rl  = CHUNK_LIMIT;
                rlf = 0;
            end else if (rl + rlf > CHUNK_LIMIT) begin
                rlf = CHUNK_LIMIT - rl;
            end

            if (s.rx_mode == MODE_OVERFLOW && pl != 0) bad = 1'b1;

            noff = off + rl + rlf;
            if (noff >= cyc) noff -= cyc;
            unread = (noff < q && ep == cyc) || (noff >= q && ep == q);

            r.new_prime_ptr = s.prime_ptr;
            r.new_prime_len = s.prime_len;
            r.new_alt_ptr   = s.alt_ptr;
            r.new_alt_len   = s.alt_len;
            r.new_mode      = s.rx_mode;
            if (unread) begin
                if (ea != 0) bad = 1'b1;
            end else begin
                nb = (ep == cyc) ? 0 : q;
                if (s.rx_mode == MODE_OVERFLOW) begin
                    r.rewrite_kind  = KIND_OVF_RST;
                    r.new_prime_ptr = PTR_W'(nb);
                    r.new_prime_len = PTR_W'(q);
                    r.new_alt_ptr   = '0;
                    r.new_alt_len   = '0;
                    r.new_mode      = MODE_LISTEN;
                end else if (ea == 0) begin
                    if (s.rx_mode != MODE_LISTEN) bad = 1'b1;
                    r.rewrite_kind = KIND_REFILL;
                    r.new_alt_ptr  = PTR_W'(nb);
                    r.new_alt_len  = PTR_W'(q);
                end
            end

            if (bad) begin
                r       = '0;
                r.fault = 1'b1;
                return r;
            end

            drain_offset = noff & 32'hFFFF;
            r.read_addr  = PTR_W'(base_rh + rho);
            r.first_len  = LEN_W'(rl);
            r.flip_addr  = PTR_W'(base_ot);
            r.flip_len   = LEN_W'(rlf);
            return r;
        endfunction

        function void note_snapshot(ppd_snap_t s);
            pending_plans.push_back(drain_plan(s));
        endfunction

        task report(string msg);
            if (mismatches < REPORT_LIMIT) $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                 plans_checked, name, got, want));
        endtask

        task check_plan(ppd_result_t got);
            ppd_result_t want;
            if (pending_plans.size() == 0) begin
                report($sformatf("word %0d arrived with nothing outstanding", plans_checked));
                plans_checked++;
                return;
            end
            want = pending_plans.pop_front();
            check_field("read_addr",     32'(got.read_addr),     32'(want.read_addr));
            check_field("first_len",     32'(got.first_len),     32'(want.first_len));
            check_field("flip_addr",     32'(got.flip_addr),     32'(want.flip_addr));
            check_field("flip_len",      32'(got.flip_len),      32'(want.flip_len));
            check_field("rewrite_kind",  32'(got.rewrite_kind),  32'(want.rewrite_kind));
            check_field("new_prime_ptr", 32'(got.new_prime_ptr), 32'(want.new_prime_ptr));
            check_field("new_prime_len", 32'(got.new_prime_len), 32'(want.new_prime_len));
            check_field("new_alt_ptr",   32'(got.new_alt_ptr),   32'(want.new_alt_ptr));
            check_field("new_alt_len",   32'(got.new_alt_len),   32'(want.new_alt_len));
            check_field("new_mode",      32'(got.new_mode),      32'(want.new_mode));
            check_field("fault",         32'(got.fault),         32'(want.fault));
            plans_checked++;
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Signals
    // -----------------------------------------------------------------------
    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [PTR_W-1:0]    s_prime_ptr;
    logic [PTR_W-1:0]    s_prime_len;
    logic [PTR_W-1:0]    s_alt_ptr;
    logic [PTR_W-1:0]    s_alt_len;
    logic [MODE_W-1:0]   s_rx_mode;
    logic                m_valid;
    logic                m_ready;
    logic [PTR_W-1:0]    m_read_addr;
    logic [LEN_W-1:0]    m_first_len;
    logic [PTR_W-1:0]    m_flip_addr;
    logic [LEN_W-1:0]    m_flip_len;
    logic [KIND_W-1:0]   m_rewrite_kind;
    logic [PTR_W-1:0]    m_new_prime_ptr;
    logic [PTR_W-1:0]    m_new_prime_len;
    logic [PTR_W-1:0]    m_new_alt_ptr;
    logic [PTR_W-1:0]    m_new_alt_len;
    logic [MODE_W-1:0]   m_new_mode;
    logic                m_fault;

    drain_checker sb = new();

    ping_pong_rx_drain_control_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_prime_ptr     (s_prime_ptr),
        .s_prime_len     (s_prime_len),
        .s_alt_ptr       (s_alt_ptr),
        .s_alt_len       (s_alt_len),
        .s_rx_mode       (s_rx_mode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_addr     (m_read_addr),
        .m_first_len     (m_first_len),
        .m_flip_addr     (m_flip_addr),
        .m_flip_len      (m_flip_len),
        .m_rewrite_kind  (m_rewrite_kind),
        .m_new_prime_ptr (m_new_prime_ptr),
        .m_new_prime_len (m_new_prime_len),
        .m_new_alt_ptr   (m_new_alt_ptr),
        .m_new_alt_len   (m_new_alt_len),
        .m_new_mode      (m_new_mode),
        .m_fault         (m_fault)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, so values seen here
    // are the ones the block saw. An input word is noted before results are
    // checked; with both stages between a word and its result, order is moot.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        ppd_snap_t   snap;
        ppd_result_t res;
        if (aresetn) begin
            if (s_valid && s_ready === 1'b1) begin
                snap.prime_ptr = s_prime_ptr;
                snap.prime_len = s_prime_len;
                snap.alt_ptr   = s_alt_ptr;
                snap.alt_len   = s_alt_len;
                snap.rx_mode   = s_rx_mode;
                sb.note_snapshot(snap);
            end
            if (m_valid === 1'b1 && m_ready) begin
                res.read_addr     = m_read_addr;
                res.first_len     = m_first_len;
                res.flip_addr     = m_flip_addr;
                res.flip_len      = m_flip_len;
                res.rewrite_kind  = m_rewrite_kind;
                res.new_prime_ptr = m_new_prime_ptr;
                res.new_prime_len = m_new_prime_len;
                res.new_alt_ptr   = m_new_alt_ptr;
                res.new_alt_len   = m_new_alt_len;
                res.new_mode      = m_new_mode;
                res.fault         = m_fault;
                sb.check_plan(res);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result side back-pressure. Each run picks a new style:
    // always ready, coin toss, mostly stalled, or a rotating bit pattern.
    // -----------------------------------------------------------------------
    initial begin
        int unsigned style, pattern, n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            style   = $urandom_range(0, 3);
            pattern = $urandom;
            for (n = 0; n < 48; n++) begin
                @(negedge aclk);
                case (style)
                    0: begin
                        m_ready = 1'b1;
                    end
                    1: begin
                        m_ready = 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready = ($urandom_range(0, 4) == 0);
                    end
                    default: begin
                        m_ready = pattern[n % 32];
                    end
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // 0 picks the low end, 1 the high end, anything else a value in between
    function automatic int unsigned span_pick(int unsigned lo, int unsigned hi,
                                              int unsigned sel);
        if (sel == 0) return lo;
        if (sel == 1) return hi;
        return $urandom_range(hi, lo);
    endfunction

    // Builds a snapshot that fits the current drain position. With the
    // alternate set, prime sits in the read half ahead of the offset; with it
    // unset, prime has moved on to the opposite half.
    function automatic ppd_snap_t shaped_snapshot(bit alt_set, logic [MODE_W-1:0] mode,
                                                  int unsigned span_sel);
        int unsigned q, off, rho, base_rh, base_ot, prime_base, p, a;
        ppd_snap_t s;
        q          = sb.quarter();
        off        = sb.drain_offset % (2 * q);
        rho        = (off >= q) ? off - q : off;
        base_rh    = (off >= q) ? q : 0;
        base_ot    = (off >= q) ? 0 : q;
        prime_base = alt_set ? base_rh : base_ot;
        p          = prime_base + span_pick(alt_set ? rho : 0, q, span_sel);
        // overflow normally comes with the prime half full
        if (mode == MODE_OVERFLOW && $urandom_range(0, 3) != 0) p = prime_base + q;
        s.prime_ptr = PTR_W'(p);
        s.prime_len = PTR_W'(prime_base + q - p);
        if (alt_set) begin
            a         = base_ot + span_pick(0, q, $urandom_range(0, 5));
            s.alt_ptr = PTR_W'(a);
            s.alt_len = PTR_W'(base_ot + q - a);
        end else begin
            s.alt_ptr = '0;
            s.alt_len = '0;
        end
        s.rx_mode = mode;
        return s;
    endfunction

    // Presents one word and holds it until accepted; valid stays high
    task send_word(ppd_snap_t s);
        s_prime_ptr = s.prime_ptr;
        s_prime_len = s.prime_len;
        s_alt_ptr   = s.alt_ptr;
        s_alt_len   = s.alt_len;
        s_rx_mode   = s.rx_mode;
        s_valid     = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task wait_drained();
        while (sb.pending_plans.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Setup then access cycle; the write lands at the edge ending the access
    // cycle. A read-back follows to check prdata.
    task write_window(int unsigned value);
        logic [DATA_W-1:0] seen;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({REG_WINDOW, 2'b00});
        pwdata  = DATA_W'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        @(negedge aclk);
        sb.set_window(value);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        seen = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (seen !== DATA_W'(value & 32'h1FFFF))
            sb.report($sformatf("window_size read back 0x%0h, expected 0x%0h",
                                seen, value & 32'h1FFFF));
    endtask

    // Random phase: bursts of words with gaps between them. Most words are
    // well-formed for the current drain position; the rest are idle
    // snapshots, pure noise or well-formed words with one field disturbed.
    task run_random_phase(int unsigned count);
        int unsigned left, burst, gap, roll, pick;
        ppd_snap_t s;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            left -= burst;
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    s         = {$urandom, $urandom, 2'b00};
                    s.rx_mode = MODE_IDLE;
                end else if (roll < 20) begin
                    s = {$urandom, $urandom, 2'($urandom_range(0, 3))};
                end else begin
                    pick = $urandom_range(0, 9);
                    s = shaped_snapshot(1'($urandom_range(0, 1)),
                                        (pick < 8) ? MODE_LISTEN :
                                        (pick < 9) ? MODE_OVERFLOW : MODE_RESERVED,
                                        $urandom_range(0, 5));
                    if (roll < 28) begin
                        case ($urandom_range(0, 4))
                            0: s.prime_ptr ^= PTR_W'(1) << $urandom_range(0, 15);
                            1: s.prime_len ^= PTR_W'(1) << $urandom_range(0, 15);
                            2: s.alt_ptr   ^= PTR_W'(1) << $urandom_range(0, 15);
                            3: s.alt_len   ^= PTR_W'(1) << $urandom_range(0, 15);
                            default: s.rx_mode = 2'($urandom_range(0, 3));
                        endcase
                    end
                end
                send_word(s);
            end
            // a quarter of bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        int unsigned i;
        int unsigned windows[10];
        ppd_snap_t fixed_cases[8];

        // inputs known from time zero; reset held low at the start
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_prime_ptr = '0;
        s_prime_len = '0;
        s_alt_ptr   = '0;
        s_alt_len   = '0;
        s_rx_mode   = MODE_IDLE;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part, reset window (quarter of 1024)
        fixed_cases = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, MODE_IDLE},      // idle, all low
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_IDLE},      // idle, all high
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, MODE_LISTEN},    // prime end off both halves
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_RESERVED},  // wide lengths, mode three
            '{16'h0000, 16'd1024, 16'h0000, 16'h0000, MODE_OVERFLOW},  // overflow with bytes left
            '{16'h0000, 16'd1024, 16'h0000, 16'd1024, MODE_LISTEN},    // both ends equal
            '{16'h0000, 16'd1024, 16'h0005, 16'h0005, MODE_LISTEN},    // alt end off both halves
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, MODE_IDLE}       // back to a clean start
        };
        foreach (fixed_cases[k]) send_word(fixed_cases[k]);
        send_word(shaped_snapshot(1'b0, MODE_LISTEN, 0));     // empty second read
        send_word(shaped_snapshot(1'b0, MODE_LISTEN, 1));
        send_word(shaped_snapshot(1'b1, MODE_LISTEN, 0));     // empty first read
        send_word(shaped_snapshot(1'b1, MODE_LISTEN, 1));
        send_word(shaped_snapshot(1'b1, MODE_LISTEN, 2));
        send_word(shaped_snapshot(1'b0, MODE_OVERFLOW, 1));
        send_word(shaped_snapshot(1'b1, MODE_OVERFLOW, 1));
        send_word(shaped_snapshot(1'b0, MODE_RESERVED, 2));   // refill outside listening
        send_word(shaped_snapshot(1'b1, MODE_RESERVED, 2));
        for (i = 0; i < 6; i++) send_word(shaped_snapshot(i[0], MODE_LISTEN, 2));
        s_valid = 1'b0;

        // Random phases. Window writes only once every word is back; the
        // drain offset is usually mid-cycle, so the re-wrap gets exercised.
        windows = '{256, 65536, 0, 131071, 1000, 32768, 4133, 12800, 768,
                    $urandom_range(1, 256) * 256};
        run_random_phase(PHASE_WORDS);
        foreach (windows[k]) begin
            wait_drained();
            write_window(windows[k]);
            run_random_phase(PHASE_WORDS);
        end

        wait_drained();
        repeat (8) @(negedge aclk);
        if (sb.pending_plans.size() != 0)
            sb.report($sformatf("%0d words never came", sb.pending_plans.size()));

        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- ping_pong_rx_drain_control_top.f -----
rtl/ppd_pkg.sv
rtl/ppd_regs.sv
rtl/ppd_offset.sv
rtl/ppd_step.sv
rtl/ping_pong_rx_drain_control_top.sv
rtl/ppd_checker.sv
tb/sv/testbench.sv
